[design/pid_motor_position_step_defines.svh]
// ----------------------------------------------------------------------------
// PID motor position step: assertion macros
// Shared assertion forms used by the checker of the PID position controller.
// ----------------------------------------------------------------------------
`ifndef PID_MOTOR_POSITION_STEP_DEFINES_SVH
`define PID_MOTOR_POSITION_STEP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIDMP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("PID checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define PIDMP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("PID checker: next-cycle property failed");

`endif

[design/pidmp_pkg.sv]
// ----------------------------------------------------------------------------
// PID motor position step: package
// Widths, register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package pidmp_pkg;

    localparam int GAIN_FRACTION_BITS = 16;
    localparam int DAC_BITS           = 12;

    localparam int POS_W   = 16;
    localparam int ERR_W   = POS_W + 1;
    localparam int DELTA_W = ERR_W + 1;
    localparam int SUM_W   = 32;
    localparam int GAIN_W  = 24;
    localparam int SCALE_W = 16;
    localparam int DRIVE_W = 16;
    localparam int MAG_W   = DRIVE_W - 1;
    localparam int DACP_W  = MAG_W + SCALE_W;

    localparam int PROD_P_W = GAIN_W + ERR_W;
    localparam int PROD_I_W = GAIN_W + SUM_W;
    localparam int PROD_D_W = GAIN_W + DELTA_W;
    localparam int ACC_W    = PROD_I_W + 2;

    localparam int IN_TDATA_W  = 2 * POS_W;
    localparam int OUT_DRIVE_LSB = 0;
    localparam int OUT_EN_BIT    = DRIVE_W;
    localparam int OUT_DIR_BIT   = DRIVE_W + 1;
    localparam int OUT_DAC_LSB   = DRIVE_W + 2;
    localparam int OUT_FIELDS_W  = OUT_DAC_LSB + DAC_BITS;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DERIV_GAIN = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DAC_SCALE  = 2'd3;

    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 24'sd6554;
    localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 24'sd0;
    localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 24'sd0;
    localparam logic [SCALE_W-1:0]       DAC_SCALE_RST  = 16'd1000;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 16'sd32767;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -16'sd32767;
    localparam logic [DAC_BITS-1:0]       DAC_MAX   = {DAC_BITS{1'b1}};

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
        logic [SCALE_W-1:0]       dac_scale;
    } t_cfg;

endpackage

[design/pidmp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// PID motor position step: configuration registers
// Holds the three loop gains and the DAC scale, written through a plain port.
// ----------------------------------------------------------------------------
module pidmp_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [pidmp_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [pidmp_pkg::CFG_DATA_W-1:0]    i_cfg_wr_data,
    output pidmp_pkg::t_cfg                     o_cfg
);

    pidmp_pkg::t_cfg r_cfg;
    pidmp_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                pidmp_pkg::REG_PROP_GAIN:  n_cfg.prop_gain  = $signed(i_cfg_wr_data);
                pidmp_pkg::REG_INTEG_GAIN: n_cfg.integ_gain = $signed(i_cfg_wr_data);
                pidmp_pkg::REG_DERIV_GAIN: n_cfg.deriv_gain = $signed(i_cfg_wr_data);
                pidmp_pkg::REG_DAC_SCALE:
                    n_cfg.dac_scale = i_cfg_wr_data[pidmp_pkg::SCALE_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain  <= pidmp_pkg::PROP_GAIN_RST;
            r_cfg.integ_gain <= pidmp_pkg::INTEG_GAIN_RST;
            r_cfg.deriv_gain <= pidmp_pkg::DERIV_GAIN_RST;
            r_cfg.dac_scale  <= pidmp_pkg::DAC_SCALE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[design/pid_motor_position_step.sv]
// ----------------------------------------------------------------------------
// PID motor position step: top level
// Discrete PID position controller producing drive, enable, direction and DAC.
// ----------------------------------------------------------------------------
// The block takes one position sample per clock while s_axis_tready is high
// and returns one result beat per sample, in the order of the samples.
// The work runs through a six-stage register pipeline: input capture, error and
// saturating error sum, the three gain products, their sum, truncation with
// saturation, and the DAC scaling; the 24 by 32 bit integral product sets the
// longest path. A stalled output only holds back the stages that are full, so
// empty stages keep taking samples. Gains are to be written only while no sample
// is in flight, not enforced by the block, and take effect from the next sample.
module pid_motor_position_step (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [pidmp_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [pidmp_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [15:0] reference_position, [31:16] measured_position
    input  logic [pidmp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [15:0] drive_value, [16] motor_enable, [17] motor_direction,
    // [29:18] dac_code, [31:30] zero
    output logic [pidmp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int P = pidmp_pkg::POS_W;
    localparam int F = pidmp_pkg::GAIN_FRACTION_BITS;

    pidmp_pkg::t_cfg cfg;

    pidmp_cfg_regs u_cfg_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cfg         (cfg)
    );

    // Valid flags of the six stages and the load enables derived from them.
    logic [6:1] r_vld;
    logic [6:1] ld;

    always_comb begin
        ld[6] = !r_vld[6] || m_axis_tready;
        for (int k = 5; k >= 1; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    assign s_axis_tready = ld[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[1]) r_vld[1] <= s_axis_tvalid;
            for (int k = 2; k <= 6; k++) begin
                if (ld[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Stage 1: sample capture.
    logic signed [P-1:0] r_ref;
    logic signed [P-1:0] r_meas;

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_ref  <= $signed(s_axis_tdata[P-1:0]);
            r_meas <= $signed(s_axis_tdata[2*P-1:P]);
        end
    end

    // Stage 2: error, derivative and the saturating error sum (loop state).
    logic signed [pidmp_pkg::ERR_W-1:0]   r_last_err;
    logic signed [pidmp_pkg::SUM_W-1:0]   r_err_sum;
    logic signed [pidmp_pkg::ERR_W-1:0]   n_err;
    logic signed [pidmp_pkg::DELTA_W-1:0] n_delta;
    logic signed [pidmp_pkg::SUM_W:0]     sum_wide;
    logic signed [pidmp_pkg::SUM_W-1:0]   n_err_sum;
    logic signed [pidmp_pkg::ERR_W-1:0]   r_err;
    logic signed [pidmp_pkg::DELTA_W-1:0] r_delta;
    logic signed [pidmp_pkg::SUM_W-1:0]   r_sum;
    logic                                 r_dir2;

    always_comb begin
        n_err    = pidmp_pkg::ERR_W'(r_ref) - pidmp_pkg::ERR_W'(r_meas);
        n_delta  = pidmp_pkg::DELTA_W'(n_err) - pidmp_pkg::DELTA_W'(r_last_err);
        sum_wide = (pidmp_pkg::SUM_W+1)'(r_err_sum) + (pidmp_pkg::SUM_W+1)'(n_err);
        if (sum_wide[pidmp_pkg::SUM_W] != sum_wide[pidmp_pkg::SUM_W-1]) begin
            n_err_sum = sum_wide[pidmp_pkg::SUM_W]
                      ? {1'b1, {(pidmp_pkg::SUM_W-1){1'b0}}}
                      : {1'b0, {(pidmp_pkg::SUM_W-1){1'b1}}};
        end else begin
            n_err_sum = sum_wide[pidmp_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err <= '0;
            r_err_sum  <= '0;
        end else if (ld[2] && r_vld[1]) begin
            r_last_err <= n_err;
            r_err_sum  <= n_err_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r_err   <= n_err;
            r_delta <= n_delta;
            r_sum   <= n_err_sum;
            r_dir2  <= !(n_err > 0);
        end
    end

    // Stage 3: the three gain products.
    logic signed [pidmp_pkg::PROD_P_W-1:0] r_prod_p;
    logic signed [pidmp_pkg::PROD_I_W-1:0] r_prod_i;
    logic signed [pidmp_pkg::PROD_D_W-1:0] r_prod_d;
    logic                                  r_dir3;

    always_ff @(posedge i_clk) begin
        if (ld[3]) begin
            r_prod_p <= pidmp_pkg::PROD_P_W'(cfg.prop_gain)
                      * pidmp_pkg::PROD_P_W'(r_err);
            r_prod_i <= pidmp_pkg::PROD_I_W'(cfg.integ_gain)
                      * pidmp_pkg::PROD_I_W'(r_sum);
            r_prod_d <= pidmp_pkg::PROD_D_W'(cfg.deriv_gain)
                      * pidmp_pkg::PROD_D_W'(r_delta);
            r_dir3   <= r_dir2;
        end
    end

    // Stage 4: fixed-point sum.
    logic signed [pidmp_pkg::ACC_W-1:0] r_acc;
    logic                               r_dir4;

    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r_acc  <= pidmp_pkg::ACC_W'(r_prod_p) + pidmp_pkg::ACC_W'(r_prod_i)
                    + pidmp_pkg::ACC_W'(r_prod_d);
            r_dir4 <= r_dir3;
        end
    end

    // Stage 5: truncation toward zero and saturation of the drive.
    logic signed [pidmp_pkg::ACC_W-1:0]   acc_bias;
    logic signed [pidmp_pkg::ACC_W-1:0]   quot;
    logic signed [pidmp_pkg::DRIVE_W-1:0] n_drive;
    logic signed [pidmp_pkg::DRIVE_W-1:0] r_drive5;
    logic [pidmp_pkg::MAG_W-1:0]          r_mag;
    logic                                 r_dir5;

    always_comb begin
        acc_bias = r_acc[pidmp_pkg::ACC_W-1]
                 ? r_acc + pidmp_pkg::ACC_W'((64'd1 << F) - 64'd1)
                 : r_acc;
        quot = acc_bias >>> F;
        if (quot > pidmp_pkg::ACC_W'(pidmp_pkg::DRIVE_MAX)) begin
            n_drive = pidmp_pkg::DRIVE_MAX;
        end else if (quot < pidmp_pkg::ACC_W'(pidmp_pkg::DRIVE_MIN)) begin
            n_drive = pidmp_pkg::DRIVE_MIN;
        end else begin
            n_drive = quot[pidmp_pkg::DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[5]) begin
            r_drive5 <= n_drive;
            r_mag    <= n_drive[pidmp_pkg::DRIVE_W-1]
                      ? pidmp_pkg::MAG_W'(-n_drive)
                      : n_drive[pidmp_pkg::MAG_W-1:0];
            r_dir5   <= r_dir4;
        end
    end

    // Stage 6: DAC scaling and the output register.
    logic [pidmp_pkg::DACP_W-1:0]         dac_prod;
    logic [pidmp_pkg::DAC_BITS-1:0]       n_dac;
    logic signed [pidmp_pkg::DRIVE_W-1:0] r_drive;
    logic                                 r_en;
    logic                                 r_dir;
    logic [pidmp_pkg::DAC_BITS-1:0]       r_dac;

    always_comb begin
        dac_prod = pidmp_pkg::DACP_W'(r_mag) * pidmp_pkg::DACP_W'(cfg.dac_scale);
        if (dac_prod > pidmp_pkg::DACP_W'(pidmp_pkg::DAC_MAX)) begin
            n_dac = pidmp_pkg::DAC_MAX;
        end else begin
            n_dac = dac_prod[pidmp_pkg::DAC_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[6]) begin
            r_drive <= r_drive5;
            r_en    <= (r_drive5 != '0);
            r_dir   <= r_dir5;
            r_dac   <= n_dac;
        end
    end

    assign m_axis_tvalid = r_vld[6];
    assign m_axis_tdata  = pidmp_pkg::OUT_TDATA_W'({r_dac, r_dir, r_en, r_drive});

endmodule

[design/pidmp_checker.sv]
// ----------------------------------------------------------------------------
// PID motor position step: port checker
// Watches the result stream of the controller and checks its field relations.
// ----------------------------------------------------------------------------
`include "pid_motor_position_step_defines.svh"

module pidmp_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [pidmp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    logic [pidmp_pkg::DRIVE_W-1:0]  drive;
    logic                           en;
    logic [pidmp_pkg::DAC_BITS-1:0] dac;

    assign drive = m_axis_tdata[pidmp_pkg::OUT_DRIVE_LSB +: pidmp_pkg::DRIVE_W];
    assign en    = m_axis_tdata[pidmp_pkg::OUT_EN_BIT];
    assign dac   = m_axis_tdata[pidmp_pkg::OUT_DAC_LSB +: pidmp_pkg::DAC_BITS];

    `PIDMP_ASSERT_NOW(a_enable_matches_drive, m_axis_tvalid, en == (drive != '0))
    `PIDMP_ASSERT_NOW(a_drive_symmetric, m_axis_tvalid, drive != {1'b1, {(pidmp_pkg::DRIVE_W-1){1'b0}}})
    `PIDMP_ASSERT_NOW(a_idle_dac_zero, m_axis_tvalid && !en, dac == '0)
    `PIDMP_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind pid_motor_position_step pidmp_checker u_pidmp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// PID motor position step: self-checking testbench
// Sends position samples over the input stream and checks every result beat
// against a cycle-free predictor of the controller: error, saturating sum,
// derivative, drive from Q8.16 gains with truncation and clamp, enable, direction and DAC.
// Gains are changed between runs of samples while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pidmp_pkg::*;

    localparam logic signed [GAIN_W-1:0] GAIN_MAX = 24'sh7F_FFFF;
    localparam logic signed [GAIN_W-1:0] GAIN_MIN = 24'sh80_0000;
    localparam longint SUM_MAX        = (longint'(1) << (SUM_W - 1)) - 1;
    localparam longint SUM_MIN        = -(longint'(1) << (SUM_W - 1));
    localparam int     STALL_LIMIT    = 2000;
    localparam int     SETTLE_CYCLES  = 10;
    localparam int     RAND_PHASES    = 9;
    localparam int     PHASE_SAMPLES  = 48;

    typedef struct packed {
        logic signed [POS_W-1:0] encoder_pos;
        logic signed [POS_W-1:0] target_pos;
    } t_sample;

    typedef struct packed {
        logic [OUT_TDATA_W-OUT_FIELDS_W-1:0] pad;
        logic [DAC_BITS-1:0]                 dac_code;
        logic                                motor_dir;
        logic                                motor_en;
        logic signed [DRIVE_W-1:0]           drive;
    } t_drive_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [15:0] reference_position, [31:16] measured_position
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [15:0] drive_value, [16] motor_enable, [17] motor_direction,
    // [29:18] dac_code, [31:30] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    t_sample                 pending_q[$];
    t_drive_result           drive_expect_q[$];
    t_cfg                    cfg_shadow;
    logic signed [ERR_W-1:0] last_err;
    logic signed [SUM_W-1:0] err_sum;
    logic                    sample_fired = 1'b0;
    int unsigned             send_idle_pct = 0;
    int unsigned             take_stall_pct = 0;
    int unsigned             samples_queued = 0;
    int unsigned             samples_sent = 0;
    int unsigned             results_seen = 0;
    int unsigned             cfg_writes = 0;
    int unsigned             mismatches = 0;
    int unsigned             idle_cycles = 0;

    pid_motor_position_step dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_drive_result pid_step_predict(input t_sample s);
        longint        e, d, sum, acc, u, mag, dac;
        t_drive_result r;
        e = longint'(s.target_pos) - longint'(s.encoder_pos);
        d = e - longint'(last_err);
        sum = longint'(err_sum) + e;
        if (sum > SUM_MAX) sum = SUM_MAX;
        if (sum < SUM_MIN) sum = SUM_MIN;
        err_sum = sum[SUM_W-1:0];
        last_err = e[ERR_W-1:0];
        acc = longint'($signed(cfg_shadow.prop_gain)) * e
            + longint'($signed(cfg_shadow.integ_gain)) * sum
            + longint'($signed(cfg_shadow.deriv_gain)) * d;
        u = acc / (longint'(1) << GAIN_FRACTION_BITS);
        if (u > longint'(DRIVE_MAX)) u = longint'(DRIVE_MAX);
        if (u < longint'(DRIVE_MIN)) u = longint'(DRIVE_MIN);
        mag = (u < 0) ? -u : u;
        dac = mag * longint'(cfg_shadow.dac_scale);
        if (dac > longint'(DAC_MAX)) dac = longint'(DAC_MAX);
        r.pad = '0;
        r.dac_code = dac[DAC_BITS-1:0];
        r.motor_dir = (e > 0) ? 1'b0 : 1'b1;
        r.motor_en = (u != 0);
        r.drive = u[DRIVE_W-1:0];
        return r;
    endfunction

    function automatic logic signed [GAIN_W-1:0] pick_gain();
        logic signed [GAIN_W-1:0] g;
        g = GAIN_W'($urandom());
        return g >>> $urandom_range(GAIN_W - 1);
    endfunction

    function automatic logic signed [POS_W-1:0] pick_corner();
        case ($urandom_range(4))
            0: return 16'sh8000;
            1: return -16'sd1;
            2: return 16'sd0;
            3: return 16'sd1;
            default: return 16'sh7FFF;
        endcase
    endfunction

    task automatic queue_sample(input logic signed [POS_W-1:0] tgt,
                                input logic signed [POS_W-1:0] enc);
        t_sample s;
        s.target_pos = tgt;
        s.encoder_pos = enc;
        pending_q.push_back(s);
        samples_queued++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        while (samples_sent != samples_queued || results_seen != samples_sent)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_gains(input logic signed [GAIN_W-1:0] kp, ki, kd,
                               input logic [CFG_DATA_W-1:0] scale_word);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= REG_PROP_GAIN;
        i_cfg_wr_data <= kp;
        @(negedge i_clk);
        i_cfg_addr <= REG_INTEG_GAIN;
        i_cfg_wr_data <= ki;
        @(negedge i_clk);
        i_cfg_addr <= REG_DERIV_GAIN;
        i_cfg_wr_data <= kd;
        @(negedge i_clk);
        i_cfg_addr <= REG_DAC_SCALE;
        i_cfg_wr_data <= scale_word;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    always @(negedge i_clk) begin : driver
        if (!s_axis_tvalid || sample_fired) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tdata <= pending_q.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= take_stall_pct);
    end

    always @(posedge i_clk) begin : monitor
        t_drive_result got;
        t_drive_result want;
        logic          busy;
        if (!i_rst_n) begin
            cfg_shadow = '{PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, DAC_SCALE_RST};
            last_err = '0;
            err_sum = '0;
            sample_fired = 1'b0;
            idle_cycles = 0;
        end else begin
            busy = 1'b0;
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    REG_PROP_GAIN:  cfg_shadow.prop_gain = i_cfg_wr_data;
                    REG_INTEG_GAIN: cfg_shadow.integ_gain = i_cfg_wr_data;
                    REG_DERIV_GAIN: cfg_shadow.deriv_gain = i_cfg_wr_data;
                    REG_DAC_SCALE:  cfg_shadow.dac_scale = i_cfg_wr_data[SCALE_W-1:0];
                    default: ;
                endcase
                cfg_writes++;
                busy = 1'b1;
            end
            sample_fired = s_axis_tvalid && s_axis_tready;
            if (sample_fired) begin
                drive_expect_q.push_back(pid_step_predict(t_sample'(s_axis_tdata)));
                samples_sent++;
                busy = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_drive_result'(m_axis_tdata);
                results_seen++;
                busy = 1'b1;
                if (drive_expect_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("tb_top: result beat %0d arrived with nothing expected",
                                 results_seen);
                    mismatches++;
                end else begin
                    want = drive_expect_q.pop_front();
                    if (got.drive !== want.drive || got.motor_en !== want.motor_en ||
                        got.motor_dir !== want.motor_dir ||
                        got.dac_code !== want.dac_code) begin
                        if (mismatches < 10) begin
                            $display("tb_top: beat %0d expected drive %0d en %b dir %b dac %0d",
                                     results_seen, want.drive, want.motor_en,
                                     want.motor_dir, want.dac_code);
                            $display("tb_top: beat %0d got drive %0d en %b dir %b dac %0d",
                                     results_seen, got.drive, got.motor_en,
                                     got.motor_dir, got.dac_code);
                        end
                        mismatches++;
                    end
                end
            end
            idle_cycles = busy ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_top: no beat moved for %0d cycles", idle_cycles);
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned             ph;
        int unsigned             k;
        logic signed [POS_W-1:0] tgt;
        logic signed [POS_W-1:0] enc;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 13;
        take_stall_pct = 51;
        queue_sample(16'sd0, 16'sd0);
        queue_sample(16'sh7FFF, 16'sh8000);
        queue_sample(16'sh8000, 16'sh7FFF);
        queue_sample(16'sh7FFF, 16'sh8000);
        queue_sample(16'sd100, 16'sd100);
        queue_sample(16'sd9, 16'sd0);
        queue_sample(-16'sd9, 16'sd0);
        queue_sample(16'sd10, 16'sd0);
        queue_sample(-16'sd10, 16'sd0);
        queue_sample(16'sd0, 16'sh8000);
        queue_sample(16'sh8000, 16'sd0);
        queue_sample(16'sh7FFF, 16'sh7FFF);
        queue_sample(16'sh8000, 16'sh8000);
        queue_sample(16'sd1, 16'sd0);
        settle();

        write_gains(GAIN_MAX, GAIN_MIN, GAIN_MAX, 24'hFF_FFFF);
        @(posedge i_clk);
        queue_sample(16'sh7FFF, 16'sh8000);
        queue_sample(16'sh8000, 16'sh7FFF);
        queue_sample(16'sd0, 16'sd0);
        queue_sample(16'sd1, 16'sd0);
        queue_sample(-16'sd1, 16'sd0);
        queue_sample(16'sd0, 16'sd1);
        queue_sample(16'sh7FFF, 16'sh8000);
        queue_sample(16'sd0, 16'sd0);
        settle();

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: write_gains(GAIN_MIN, 24'sd1, GAIN_MIN, 24'd0);
                1: write_gains(24'sd0, 24'sd0, 24'sd0, 24'd1);
                default: write_gains(pick_gain(), pick_gain(), pick_gain(),
                                     {8'($urandom()), 16'($urandom()) >> $urandom_range(15)});
            endcase
            @(posedge i_clk);
            case (ph / 3)
                0: begin
                    send_idle_pct = 13;
                    take_stall_pct = 51;
                end
                1: begin
                    send_idle_pct = 51;
                    take_stall_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    take_stall_pct = 0;
                end
            endcase
            for (k = 0; k < PHASE_SAMPLES; k++) begin
                case ($urandom_range(3))
                    0: begin
                        tgt = POS_W'($urandom());
                        enc = POS_W'($urandom());
                    end
                    1: begin
                        tgt = POS_W'($urandom());
                        enc = tgt + $signed(8'($urandom()));
                    end
                    2: begin
                        tgt = pick_corner();
                        enc = pick_corner();
                    end
                    default: begin
                        tgt = POS_W'($signed(10'($urandom())));
                        enc = POS_W'($signed(10'($urandom())));
                    end
                endcase
                queue_sample(tgt, enc);
            end
            settle();
        end

        if (drive_expect_q.size() != 0) begin
            $display("tb_top: %0d expected beats never arrived", drive_expect_q.size());
            mismatches += drive_expect_q.size();
        end
        $display("tb_top: %0d samples checked under %0d register writes and three idling mixes",
                 results_seen, cfg_writes);
        $display("tb_top: corner positions, extreme and random gains, %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
